// ----- design/clf_pkg.sv -----
// Shared types and constants for the CR/LF line framer.
// Used by clf_core, clf_fifo and crlf_line_framer; depends on nothing.
package clf_pkg;

  localparam int LINE_BYTES = 512;
  localparam int CNT_W      = $clog2(LINE_BYTES);
  localparam int LEN_W      = 9;

  localparam logic [CNT_W-1:0] KEPT_CAP = CNT_W'(LINE_BYTES - 1);

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_EOL  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       data;
    logic [LEN_W-1:0] len;
    logic             trunc;
    logic             last;
  } res_t;

  // Up to two results produced by one input byte.
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

// ----- design/crlf_line_framer.sv -----
// Top level of the CR/LF line framer: input register, framing core, result queue.
// Depends on clf_pkg, clf_core and clf_fifo.
//
// Usage: bytes enter on in_valid/in_ready/in_byte, one transaction per byte.
// Results leave on out_valid/out_ready with out_kind (data, end of line, zero
// byte error), out_byte, out_line_length, out_truncated and out_last; out_last
// marks the final result caused by one input byte.
// cfg_wr_en/cfg_wr_data write raw_mode (1 keeps CR/LF in the line). Write it
// only while no transaction is in flight.
// A byte waits in the input register until the core steps on it; its results are
// written to the queue and offered from there. Throughput: one byte per clock while
// the queue has room; a raw-run end byte makes two results, which leave one at a
// time. The core steps when a byte waits and the four-entry queue has room for two.
// Reset (synchronous, rst_n low) empties the pipeline, clears raw_mode and
// opens an empty line in text phase.
// When the receiver stalls, results collect in the queue; in_ready drops once
// fewer than two entries are free and the pending byte stays in its register.
module crlf_line_framer (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_byte,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               out_kind,
  output logic [7:0]               out_byte,
  output logic [clf_pkg::LEN_W-1:0] out_line_length,
  output logic                     out_truncated,
  output logic                     out_last,
  input  logic                     cfg_wr_en,
  input  logic                     cfg_wr_data
);
  import clf_pkg::*;

  logic       hold_valid_r;
  logic [7:0] hold_byte_r;
  logic       raw_mode_r;
  logic       room, step;
  push_t      push;
  res_t       head;

  assign step     = hold_valid_r && room;
  assign in_ready = !hold_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      raw_mode_r   <= 1'b0;
    end else begin
      if (in_valid && in_ready) hold_valid_r <= 1'b1;
      else if (step)            hold_valid_r <= 1'b0;
      if (cfg_wr_en) raw_mode_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) hold_byte_r <= in_byte;
  end

  clf_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .data     (hold_byte_r),
    .raw_mode (raw_mode_r),
    .push     (push)
  );

  clf_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_kind        = head.kind;
  assign out_byte        = head.data;
  assign out_line_length = head.len;
  assign out_truncated   = head.trunc;
  assign out_last        = head.last;

  a_hold_until_step: assert property (@(posedge clk) disable iff (!rst_n)
    (hold_valid_r && !room) |=> (hold_valid_r && $stable(hold_byte_r)))
    else $error("pending byte lost while queue was full");

endmodule

// ----- design/clf_core.sv -----
// Line framing state machine: decodes one byte per step into zero to two results.
// Depends on clf_pkg.
module clf_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  logic [7:0]     data,
  input  logic           raw_mode,
  output clf_pkg::push_t push
);
  import clf_pkg::*;

  localparam logic [1:0] PH_TEXT       = 2'd0;
  localparam logic [1:0] PH_OPEN_RUN   = 2'd1;
  localparam logic [1:0] PH_DISCARD    = 2'd2;
  localparam logic [1:0] PH_CLOSED_RUN = 2'd3;

  typedef struct packed {
    res_t             res;
    logic [CNT_W-1:0] kept;
    logic [1:0]       phase;
  } tb_t;

  logic [CNT_W-1:0] kept_r, kept_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic             is_eol, is_nul;
  tb_t              tb_cur, tb_zero;
  res_t             eol_res;

  // A byte that sits in text position of an open line.
  function automatic tb_t text_step(logic [7:0] b, logic [CNT_W-1:0] kept, logic raw);
    tb_t t;
    logic eol;
    eol = (b == CHAR_CR) || (b == CHAR_LF);
    t = '0;
    if (b == CHAR_NUL) begin
      t.res.kind = KIND_ERR;
      t.kept     = '0;
      t.phase    = PH_TEXT;
    end else if (eol && !raw) begin
      t.res.kind = KIND_EOL;
      t.res.len  = LEN_W'(kept);
      t.kept     = '0;
      t.phase    = PH_CLOSED_RUN;
    end else if (kept < KEPT_CAP) begin
      t.res.kind = KIND_DATA;
      t.res.data = b;
      t.kept     = kept + CNT_W'(1);
      t.phase    = eol ? PH_OPEN_RUN : PH_TEXT;
    end else begin
      t.res.kind  = KIND_EOL;
      t.res.len   = LEN_W'(kept);
      t.res.trunc = 1'b1;
      t.kept      = '0;
      t.phase     = eol ? PH_CLOSED_RUN : PH_DISCARD;
    end
    return t;
  endfunction

  assign is_eol  = (data == CHAR_CR) || (data == CHAR_LF);
  assign is_nul  = (data == CHAR_NUL);
  assign tb_cur  = text_step(data, kept_r, raw_mode);
  assign tb_zero = text_step(data, '0, raw_mode);

  always_comb begin
    eol_res      = '0;
    eol_res.kind = KIND_EOL;
    eol_res.len  = LEN_W'(kept_r);
  end

  always_comb begin
    push      = '0;
    kept_nxt  = kept_r;
    phase_nxt = phase_r;
    case (phase_r)
      PH_TEXT: begin
        push.n    = 2'd1;
        push.r0   = tb_cur.res;
        kept_nxt  = tb_cur.kept;
        phase_nxt = tb_cur.phase;
      end
      PH_OPEN_RUN: begin
        if (is_eol) begin
          push.n    = 2'd1;
          push.r0   = tb_cur.res;
          kept_nxt  = tb_cur.kept;
          phase_nxt = tb_cur.phase;
        end else begin
          // The raw run is over: close the line, then the byte opens the next one.
          push.n    = 2'd2;
          push.r0   = eol_res;
          push.r1   = tb_zero.res;
          kept_nxt  = tb_zero.kept;
          phase_nxt = tb_zero.phase;
        end
      end
      PH_DISCARD: begin
        if (is_nul) begin
          push.n    = 2'd1;
          push.r0   = tb_zero.res;
          kept_nxt  = '0;
          phase_nxt = PH_TEXT;
        end else if (is_eol) begin
          phase_nxt = PH_CLOSED_RUN;
        end
      end
      PH_CLOSED_RUN: begin
        if (!is_eol) begin
          push.n    = 2'd1;
          push.r0   = tb_zero.res;
          kept_nxt  = tb_zero.kept;
          phase_nxt = tb_zero.phase;
        end
      end
      default: begin
        phase_nxt = PH_TEXT;
        kept_nxt  = '0;
      end
    endcase
    if (push.n == 2'd1) push.r0.last = 1'b1;
    if (push.n == 2'd2) push.r1.last = 1'b1;
    if (!step) push.n = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kept_r  <= '0;
      phase_r <= PH_TEXT;
    end else if (step) begin
      kept_r  <= kept_nxt;
      phase_r <= phase_nxt;
    end
  end

  a_kept_capped: assert property (@(posedge clk) disable iff (!rst_n)
    kept_r <= KEPT_CAP)
    else $error("kept count beyond line cap");

  a_closed_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DISCARD || phase_r == PH_CLOSED_RUN) |-> kept_r == '0)
    else $error("kept bytes left after line was closed");

  a_pair_only_on_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n == 2'd2) |-> (phase_r == PH_OPEN_RUN && push.r0.kind == KIND_EOL))
    else $error("two results outside the end of a raw run");

endmodule

// ----- design/clf_fifo.sv -----
// Four-entry result queue in flip-flops: takes up to two results a cycle, gives one.
// Depends on clf_pkg.
module clf_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  clf_pkg::push_t push,
  output logic           room,
  output logic           out_valid,
  input  logic           out_ready,
  output clf_pkg::res_t  head
);
  import clf_pkg::*;

  res_t              mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [FCNT_W-1:0] count_r, count_nxt;
  logic              pop;

  assign out_valid = (count_r != '0);
  assign pop       = out_valid && out_ready;
  assign head      = mem_r[rd_ptr_r];
  // Room is always kept for a full pair so the core never has to stall mid-byte.
  assign room      = (count_r <= FCNT_W'(FIFO_DEPTH - 2));
  assign count_nxt = count_r + FCNT_W'(push.n) - FCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem_r[wr_ptr_r] <= push.r0;
    if (push.n == 2'd2) mem_r[PTR_W'(wr_ptr_r + PTR_W'(1))] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= PTR_W'(wr_ptr_r + PTR_W'(push.n));
      if (pop) rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      count_r <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0) |-> room)
    else $error("result pushed without room");

  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FCNT_W'(FIFO_DEPTH))
    else $error("result queue count out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    PTR_W'(wr_ptr_r - rd_ptr_r) == PTR_W'(count_r))
    else $error("queue pointers disagree with count");

endmodule
